[src/rtcsm_pkg.sv]
// Shared types and constants for the three-wire RTC serial master.
// No dependencies; used by the queue, the engine and the top level.
`default_nettype none

package rtcsm_pkg;

    // Slot layout of one transfer.
    localparam int unsigned SLOT_W        = 7;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned BIT_IDX_W     = 3;
    localparam int unsigned PHASE_W       = 2;
    localparam int unsigned SLOT_TICKS_W  = 16;

    localparam logic [SLOT_W-1:0] CMD_FIRST    = 7'd2;
    localparam logic [SLOT_W-1:0] DATA_FIRST   = 7'd34;
    localparam logic [SLOT_W-1:0] TAIL_FIRST   = 7'd66;
    localparam logic [SLOT_W-1:0] CE_LOW_FIRST = 7'd68;
    localparam logic [SLOT_W-1:0] LAST_SLOT    = 7'd69;

    // Phases inside one bit period.
    localparam logic [PHASE_W-1:0] PH_LOW_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DATA     = 2'd1;
    localparam logic [PHASE_W-1:0] PH_CLK_HIGH = 2'd2;
    localparam logic [PHASE_W-1:0] PH_TRAIL    = 2'd3;

    localparam logic [SLOT_TICKS_W-1:0] SLOT_TICKS_RESET = 16'd100;

    // Two-entry queues on both sides of the engine.
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;
    localparam logic [Q_CNT_W-1:0] Q_DEPTH = 2'd2;

    // One timebase tick as it enters the block.
    typedef struct packed {
        logic              start_req;
        logic              req_type;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] write_data;
        logic              io_in;
    } t_item;

    // Line levels and status for one tick.
    typedef struct packed {
        logic              chip_enable;
        logic              serial_clock;
        logic              io_out;
        logic              io_drive;
        logic [BYTE_W-1:0] read_result;
        logic              done_res;
        logic              busy_res;
    } t_res;

    localparam int unsigned ITEM_W = $bits(t_item);
    localparam int unsigned RES_W  = $bits(t_res);

endpackage

`default_nettype wire

[src/rtcsm_queue.sv]
// Two-entry request queue used in front of and behind the transfer engine.
// Depends on rtcsm_pkg for the depth and pointer widths.
`default_nettype none

module rtcsm_queue #(
    parameter int unsigned WIDTH = 19
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0]                r_mem [2];
    logic [rtcsm_pkg::Q_PTR_W-1:0]   r_wr;
    logic [rtcsm_pkg::Q_PTR_W-1:0]   r_rd;
    logic [rtcsm_pkg::Q_CNT_W-1:0]   r_cnt;
    logic [rtcsm_pkg::Q_CNT_W-1:0]   n_cnt;
    logic                            do_push;
    logic                            do_pop;

    // Handshake status.
    assign o_full  = (r_cnt == rtcsm_pkg::Q_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Occupancy update.
    always_comb begin
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[src/rtcsm_engine.sv]
// Transfer engine: steps the slot sequencer by one timebase tick per request.
// Depends on rtcsm_pkg for the slot layout and the tick and result structs.
`default_nettype none

module rtcsm_engine #(
    parameter int unsigned TICK_COUNTER_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_fire,
    input  wire rtcsm_pkg::t_item               i_item,
    input  wire [rtcsm_pkg::SLOT_TICKS_W-1:0]   i_slot_ticks,
    output rtcsm_pkg::t_res                     o_res
);

    localparam int unsigned TC_W  = TICK_COUNTER_BITS;
    localparam int unsigned CMP_W = ((TC_W > rtcsm_pkg::SLOT_TICKS_W) ?
                                     TC_W : rtcsm_pkg::SLOT_TICKS_W) + 1;

    logic                                r_active;
    logic                                r_is_read;
    logic [rtcsm_pkg::SLOT_W-1:0]        r_slot;
    logic [TC_W-1:0]                     r_tc;
    logic [rtcsm_pkg::BYTE_W-1:0]        r_cmd;
    logic [rtcsm_pkg::BYTE_W-1:0]        r_data;
    logic [rtcsm_pkg::BYTE_W-1:0]        r_accum;

    logic                                start;
    logic                                act;
    logic                                is_read;
    logic [rtcsm_pkg::SLOT_W-1:0]        slot;
    logic [TC_W-1:0]                     tc;
    logic [rtcsm_pkg::BYTE_W-1:0]        cmd;
    logic [rtcsm_pkg::BYTE_W-1:0]        data;
    logic [rtcsm_pkg::BYTE_W-1:0]        accum;
    logic [rtcsm_pkg::BYTE_W-1:0]        n_accum;
    logic [rtcsm_pkg::SLOT_TICKS_W-1:0]  len_m1;
    logic                                slot_end;
    logic                                last;
    logic                                in_cmd;
    logic                                in_data;
    logic [rtcsm_pkg::SLOT_W-1:0]        cmd_off;
    logic [rtcsm_pkg::SLOT_W-1:0]        data_off;
    logic [rtcsm_pkg::BIT_IDX_W-1:0]     bit_idx;
    logic [rtcsm_pkg::PHASE_W-1:0]       phase;
    logic                                tx_bit;

    // A start is taken only while no transfer is running.
    assign start   = !r_active && i_item.start_req;
    assign act     = r_active || start;
    assign is_read = start ? i_item.req_type   : r_is_read;
    assign cmd     = start ? i_item.command    : r_cmd;
    assign data    = start ? i_item.write_data : r_data;
    assign accum   = start ? '0 : r_accum;
    assign slot    = start ? '0 : r_slot;
    assign tc      = start ? '0 : r_tc;

    // A slot ends on its last tick; a zero length acts as one tick.
    assign len_m1   = (i_slot_ticks == '0) ? '0 : i_slot_ticks - 1'b1;
    assign slot_end = (CMP_W'(tc) >= CMP_W'(len_m1)) || (&tc);
    assign last     = (slot >= rtcsm_pkg::LAST_SLOT);

    // Bit index and phase inside the command and data bytes.
    assign in_cmd   = (slot >= rtcsm_pkg::CMD_FIRST) && (slot < rtcsm_pkg::DATA_FIRST);
    assign in_data  = (slot >= rtcsm_pkg::DATA_FIRST) && (slot < rtcsm_pkg::TAIL_FIRST);
    assign cmd_off  = slot - rtcsm_pkg::CMD_FIRST;
    assign data_off = slot - rtcsm_pkg::DATA_FIRST;
    assign bit_idx  = in_cmd ? cmd_off[4:2] : data_off[4:2];
    assign phase    = in_cmd ? cmd_off[1:0] : data_off[1:0];
    assign tx_bit   = in_cmd ? cmd[bit_idx] : data[bit_idx];

    // Line levels, read sampling and status for this tick.
    always_comb begin
        o_res             = '0;
        o_res.io_drive    = 1'b1;
        n_accum           = accum;
        if (act) begin
            o_res.busy_res    = 1'b1;
            o_res.chip_enable = (slot < rtcsm_pkg::CE_LOW_FIRST);
            if (in_cmd || (in_data && !is_read)) begin
                o_res.serial_clock = phase[1];
                o_res.io_out = ((phase == rtcsm_pkg::PH_DATA) ||
                                (phase == rtcsm_pkg::PH_CLK_HIGH)) ? tx_bit : 1'b0;
            end else if (in_data) begin
                o_res.io_drive     = 1'b0;
                o_res.serial_clock = !phase[1];
                if ((phase == rtcsm_pkg::PH_CLK_HIGH) && slot_end) begin
                    n_accum[bit_idx] = accum[bit_idx] | i_item.io_in;
                end
            end else if ((slot >= rtcsm_pkg::TAIL_FIRST) && is_read) begin
                o_res.io_drive = 1'b0;
            end
            if (slot_end && last) begin
                o_res.done_res = 1'b1;
                if (is_read) begin
                    o_res.read_result = n_accum;
                end
            end
        end
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_is_read <= 1'b0;
            r_slot    <= '0;
            r_tc      <= '0;
        end else if (i_fire && act) begin
            r_is_read <= is_read;
            if (slot_end) begin
                r_tc <= '0;
                if (last) begin
                    r_active <= 1'b0;
                    r_slot   <= '0;
                end else begin
                    r_active <= 1'b1;
                    r_slot   <= slot + 1'b1;
                end
            end else begin
                r_active <= 1'b1;
                r_slot   <= slot;
                r_tc     <= tc + 1'b1;
            end
        end
    end

    // Transfer payload.
    always_ff @(posedge i_clk) begin
        if (i_fire && act) begin
            r_cmd   <= cmd;
            r_data  <= data;
            r_accum <= n_accum;
        end
    end

endmodule

`default_nettype wire

[src/three_wire_rtc_serial_master.sv]
// Top level of the three-wire RTC serial master.
// Depends on rtcsm_pkg, rtcsm_queue and rtcsm_engine.
//
// Usage: every request pushed on the input queue is one timebase tick with
// the start flag, read/write selector, command byte, write data and the
// sampled data line level. For every tick one request comes out of the
// result queue carrying the enable, clock and data line levels, the drive
// enable, the read byte, done and busy for that tick.
// A transfer lasts 70 quarter-bit slots of slot_ticks ticks each; the slot
// length comes from the configuration channel (reset value 100) and the
// user must write it only with no ticks in flight; block doesn't check.
// Throughput is one tick per clock cycle while the result queue has room;
// the engine steps a tick combinationally. With empty queues a tick is
// registered in the input queue, the engine computes its result
// combinationally and the result is registered in the result queue,
// from which it can be popped.
// Both queues hold two requests; when the consumer stalls the result queue
// fills, the engine pauses and then full rises on the input side.
// A synchronous active-low reset empties both queues, ends any transfer and
// restores the slot length to 100.
`default_nettype none

module three_wire_rtc_serial_master #(
    parameter int unsigned TICK_COUNTER_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // Tick input queue.
    input  wire        push,
    output logic       full,
    input  wire        i_start_req,
    input  wire        i_req_type,
    input  wire [7:0]  i_command,
    input  wire [7:0]  i_write_data,
    input  wire        i_io_in,
    // Result queue.
    output logic       empty,
    input  wire        pop,
    output logic       o_chip_enable,
    output logic       o_serial_clock,
    output logic       o_io_out,
    output logic       o_io_drive,
    output logic [7:0] o_read_result,
    output logic       o_done_res,
    output logic       o_busy_res,
    // Configuration channel.
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [15:0] i_cfg_slot_ticks
);

    logic [rtcsm_pkg::SLOT_TICKS_W-1:0] r_slot_ticks;
    rtcsm_pkg::t_item                   in_item;
    rtcsm_pkg::t_item                   head_item;
    rtcsm_pkg::t_res                    eng_res;
    rtcsm_pkg::t_res                    out_res;
    logic                               in_empty;
    logic                               out_full;
    logic                               fire;

    // Configuration register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ticks <= rtcsm_pkg::SLOT_TICKS_RESET;
        end else if (i_cfg_valid) begin
            r_slot_ticks <= i_cfg_slot_ticks;
        end
    end

    // Front: tick queue.
    always_comb begin
        in_item.start_req  = i_start_req;
        in_item.req_type   = i_req_type;
        in_item.command    = i_command;
        in_item.write_data = i_write_data;
        in_item.io_in      = i_io_in;
    end

    rtcsm_queue #(
        .WIDTH (rtcsm_pkg::ITEM_W)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_item),
        .o_full  (full),
        .i_pop   (fire),
        .o_data  (head_item),
        .o_empty (in_empty)
    );

    // Back: engine steps a queued tick whenever the result queue has room.
    assign fire = !in_empty && !out_full;

    rtcsm_engine #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (head_item),
        .i_slot_ticks (r_slot_ticks),
        .o_res        (eng_res)
    );

    rtcsm_queue #(
        .WIDTH (rtcsm_pkg::RES_W)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (eng_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    // Result fields.
    assign o_chip_enable  = out_res.chip_enable;
    assign o_serial_clock = out_res.serial_clock;
    assign o_io_out       = out_res.io_out;
    assign o_io_drive     = out_res.io_drive;
    assign o_read_result  = out_res.read_result;
    assign o_done_res     = out_res.done_res;
    assign o_busy_res     = out_res.busy_res;

endmodule

`default_nettype wire
